### rtl/tcce_pkg.sv
// shared types and constants for the text console cursor engine
package tcce_pkg;

  // fixed field widths
  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int POS_W     = 11;
  localparam int CELL_W    = 16;
  localparam int COLOR_W   = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'd126;

  // reset values
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
  localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0720;

  // classified operation
  typedef enum logic [2:0] {
    OP_NOP,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_PRINT,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [POS_W-1:0]     pos;
    logic [CELL_W-1:0]    data;
    logic                 scrolled;
  } res_t;

endpackage

### rtl/tcce_ram.sv
// generic single write port ram with registered read
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tcce_fifo.sv
// small register fifo used for the command and result queues
module tcce_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/tcce_front.sv
// front end: accepts requests, classifies them and queues commands
module tcce_front import tcce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [IDX_W-1:0]  in_cell_index,
  input  logic              back_busy,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t cls;
  logic fifo_full;
  logic fifo_empty;
  logic push_ok;

  // request decode
  always_comb begin
    cls.ch  = in_char_code;
    cls.idx = in_cell_index;
    unique case (in_req_type)
      REQ_PUT: begin
        priority if (in_char_code == CH_NEWLINE) begin
          cls.op = OP_NEWLINE;
        end else if (in_char_code == CH_RETURN) begin
          cls.op = OP_RETURN;
        end else if (in_char_code == CH_BACKSPACE) begin
          cls.op = OP_BACKSPACE;
        end else if (in_char_code >= CH_PRINT_LO && in_char_code <= CH_PRINT_HI) begin
          cls.op = OP_PRINT;
        end else begin
          cls.op = OP_NOP;
        end
      end
      REQ_CLEAR: cls.op = OP_CLEAR;
      REQ_READ:  cls.op = OP_READ;
      default:   cls.op = OP_NOP;
    endcase
  end

  // no transaction taken while the back end sweeps after reset
  assign in_full   = fifo_full || back_busy;
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = !fifo_empty;

  // command queue
  tcce_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_ok),
    .push_data (cls),
    .full      (fifo_full),
    .pop       (cmd_pop),
    .pop_data  (cmd),
    .empty     (fifo_empty)
  );

endmodule

### rtl/tcce_back.sv
// back end: cursor, screen store with row-offset scrolling, sweeps and reads
module tcce_back import tcce_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [COLOR_W-1:0] cfg_wr_data,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  output logic               busy,
  input  logic               res_full,
  output logic               res_push,
  output res_t               res
);

  localparam int NCELLS = ROWS * COLS;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam logic [ADDR_W:0]   NCELLS_X  = (ADDR_W + 1)'(NCELLS);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(NCELLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLS - 1);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SWEEP
  } state_t;

  state_t              state_r;
  logic [ROW_W-1:0]    row_r;
  logic [COL_W-1:0]    col_r;
  logic [ADDR_W-1:0]   row_base_r;
  logic [ADDR_W-1:0]   top_base_r;
  logic [COLOR_W-1:0]  color_r;
  logic [ADDR_W-1:0]   sweep_addr_r;
  logic [ADDR_W-1:0]   sweep_last_r;
  logic [CELL_W-1:0]   sweep_cell_r;
  res_t                res_r;
  logic                rd_ok_r;

  logic                take;
  logic                is_put;
  logic [CELL_W-1:0]   blank;
  logic [COL_W-1:0]    col_nxt;
  logic [ROW_W-1:0]    row_nxt;
  logic [ADDR_W-1:0]   base_nxt;
  logic                row_inc;
  logic                wr_cursor;
  logic                wr_left;
  logic                scroll;
  logic [COL_W-1:0]    wr_col;
  logic [ADDR_W-1:0]   log_addr;
  logic [ADDR_W:0]     phys_sum;
  logic [ADDR_W-1:0]   phys_addr;
  logic [ADDR_W:0]     top_sum;
  logic [ADDR_W-1:0]   top_adv;
  logic [ADDR_W-1:0]   cur_pos;
  res_t                res_put;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [CELL_W-1:0]   ram_rdata;

  assign take    = (state_r == S_IDLE) && cmd_valid && !res_full;
  assign cmd_pop = take;
  assign busy    = (state_r == S_INIT);
  assign blank   = {color_r, CH_SPACE};
  assign is_put  = (cmd.op != OP_CLEAR) && (cmd.op != OP_READ);
  assign cur_pos = row_base_r + ADDR_W'(col_r);

  // cursor movement for put commands
  always_comb begin
    col_nxt   = col_r;
    row_inc   = 1'b0;
    wr_cursor = 1'b0;
    wr_left   = 1'b0;
    unique case (cmd.op)
      OP_NEWLINE: begin
        col_nxt = '0;
        row_inc = 1'b1;
      end
      OP_RETURN: begin
        col_nxt = '0;
      end
      OP_BACKSPACE: begin
        if (col_r != '0) begin
          col_nxt   = col_r - COL_W'(1);
          wr_cursor = 1'b1;
          wr_left   = 1'b1;
        end
      end
      OP_PRINT: begin
        wr_cursor = 1'b1;
        if (col_r == COL_LAST) begin
          col_nxt = '0;
          row_inc = 1'b1;
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign scroll   = row_inc && (row_r == ROW_LAST);
  assign row_nxt  = (row_inc && !scroll) ? row_r + ROW_W'(1) : row_r;
  assign base_nxt = (row_inc && !scroll) ? row_base_r + COLS_A : row_base_r;

  // logical index to physical address through the top row offset
  assign wr_col    = wr_left ? col_r - COL_W'(1) : col_r;
  assign log_addr  = (cmd.op == OP_READ) ? ADDR_W'(cmd.idx) : row_base_r + ADDR_W'(wr_col);
  assign phys_sum  = {1'b0, log_addr} + {1'b0, top_base_r};
  assign phys_addr = (phys_sum >= NCELLS_X) ? ADDR_W'(phys_sum - NCELLS_X)
                                            : phys_sum[ADDR_W-1:0];

  // next top row offset on scroll
  assign top_sum = {1'b0, top_base_r} + {1'b0, COLS_A};
  assign top_adv = (top_sum == NCELLS_X) ? '0 : top_sum[ADDR_W-1:0];

  // result of a put command
  always_comb begin
    res_put.row      = ROW_OUT_W'(row_nxt);
    res_put.col      = COL_OUT_W'(col_nxt);
    res_put.pos      = POS_W'(base_nxt + ADDR_W'(col_nxt));
    res_put.data     = '0;
    res_put.scrolled = scroll;
  end

  // store write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys_addr;
    ram_wdata = wr_left ? blank : {color_r, cmd.ch};
    if (state_r == S_INIT || state_r == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr_r;
      ram_wdata = sweep_cell_r;
    end else if (take && is_put && wr_cursor) begin
      ram_we = 1'b1;
    end
  end

  // result transaction
  always_comb begin
    res_push = 1'b0;
    res      = res_r;
    unique case (state_r)
      S_IDLE: begin
        res_push = take && is_put && !scroll;
        res      = res_put;
      end
      S_READ: begin
        res_push = 1'b1;
        res.data = rd_ok_r ? ram_rdata : '0;
      end
      S_SWEEP: begin
        res_push = (sweep_addr_r == sweep_last_r);
      end
      S_INIT: begin
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      row_r        <= '0;
      col_r        <= '0;
      row_base_r   <= '0;
      top_base_r   <= '0;
      color_r      <= COLOR_RESET;
      sweep_addr_r <= '0;
      sweep_last_r <= ADDR_LAST;
      sweep_cell_r <= RESET_CELL;
    end else begin
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_INIT: begin
          if (sweep_addr_r == sweep_last_r) begin
            state_r <= S_IDLE;
          end else begin
            sweep_addr_r <= sweep_addr_r + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (take) begin
            unique case (cmd.op)
              OP_CLEAR: begin
                row_r        <= '0;
                col_r        <= '0;
                row_base_r   <= '0;
                top_base_r   <= '0;
                sweep_addr_r <= '0;
                sweep_last_r <= ADDR_LAST;
                sweep_cell_r <= blank;
                res_r        <= '0;
                state_r      <= S_SWEEP;
              end
              OP_READ: begin
                rd_ok_r      <= (int'(cmd.idx) < NCELLS);
                res_r.row    <= ROW_OUT_W'(row_r);
                res_r.col    <= COL_OUT_W'(col_r);
                res_r.pos    <= POS_W'(cur_pos);
                res_r.data   <= '0;
                res_r.scrolled <= 1'b0;
                state_r      <= S_READ;
              end
              default: begin
                row_r      <= row_nxt;
                col_r      <= col_nxt;
                row_base_r <= base_nxt;
                if (scroll) begin
                  // old top row becomes the new blank bottom row
                  top_base_r   <= top_adv;
                  sweep_addr_r <= top_base_r;
                  sweep_last_r <= top_base_r + COLS_A - ADDR_W'(1);
                  sweep_cell_r <= blank;
                  res_r        <= res_put;
                  state_r      <= S_SWEEP;
                end
              end
            endcase
          end
        end
        S_READ: begin
          state_r <= S_IDLE;
        end
        S_SWEEP: begin
          if (sweep_addr_r == sweep_last_r) begin
            state_r <= S_IDLE;
          end else begin
            sweep_addr_r <= sweep_addr_r + ADDR_W'(1);
          end
        end
      endcase
    end
  end

  // screen store
  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (phys_addr),
    .rdata (ram_rdata)
  );

endmodule

### rtl/text_console_cursor_engine_top.sv
// top level of the text console cursor engine
//
//  channel   direction  handshake         fields
//  in_*      input      in_push/in_full   req_type, char_code, cell_index
//  out_*     output     out_pop/out_empty cur_row, cur_col, cursor_pos, cell_data, scrolled
//  cfg_*     input      cfg_wr_en         wr_data (text color attribute)
//
// a put without scroll is done when taken; reads pass the registered store read port.
// a put that scrolls then sweeps the new bottom row, one store write per cell;
// a clear sweeps the whole store, one store write per cell.
// after reset the store is swept to blank cells with in_full held high.
// two-entry queues sit between front and back end and in front of the result port.
module text_console_cursor_engine_top import tcce_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [CHAR_W-1:0]    in_char_code,
  input  logic [IDX_W-1:0]     in_cell_index,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [ROW_OUT_W-1:0] out_cur_row,
  output logic [COL_OUT_W-1:0] out_cur_col,
  output logic [POS_W-1:0]     out_cursor_pos,
  output logic [CELL_W-1:0]    out_cell_data,
  output logic                 out_scrolled,
  input  logic                 cfg_wr_en,
  input  logic [COLOR_W-1:0]   cfg_wr_data
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic back_busy;
  logic res_full;
  logic res_push;
  res_t res;
  res_t res_head;

  // request intake and classification
  tcce_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_req_type   (in_req_type),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .back_busy     (back_busy),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // execution
  tcce_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .busy        (back_busy),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  // result queue
  tcce_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_head),
    .empty     (out_empty)
  );

  // result fields to ports
  assign out_cur_row    = res_head.row;
  assign out_cur_col    = res_head.col;
  assign out_cursor_pos = res_head.pos;
  assign out_cell_data  = res_head.data;
  assign out_scrolled   = res_head.scrolled;

endmodule

### rtl/tcce_checker.sv
// port-level checks for the text console cursor engine, bound to the top level
module tcce_checker import tcce_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_full,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic [ROW_OUT_W-1:0] out_cur_row,
  input logic [COL_OUT_W-1:0] out_cur_col,
  input logic [POS_W-1:0]     out_cursor_pos,
  input logic [CELL_W-1:0]    out_cell_data,
  input logic                 out_scrolled
);

  // reset leaves no result waiting
  assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  // store sweep after reset blocks intake
  assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("request taken during post-reset sweep");

  // cursor stays on the screen
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_cur_row < ROWS) && (out_cur_col < COLS))
    else $error("cursor off screen");

  // a scroll leaves the cursor on the last row
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_scrolled) |-> (out_cur_row == ROW_OUT_W'(ROWS - 1)))
    else $error("scroll without cursor on last row");

  // stalled result transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_cell_data)
                                  && $stable(out_cursor_pos)))
    else $error("stalled result changed");

endmodule

bind text_console_cursor_engine_top tcce_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcce_checker (.*);

### tb/sv/tb.sv
// testbench for the text console cursor engine: queue-fed driver, checking monitor
`timescale 1ns / 100ps

module tb;
  import tcce_pkg::*;

  localparam int SCR_COLS  = 80;
  localparam int SCR_ROWS  = 25;
  localparam int NCELLS    = SCR_ROWS * SCR_COLS;
  localparam int SETTLE    = NCELLS + 100;
  localparam int IDLE_PCT  = 14;
  localparam int PHASE_LEN = 280;
  localparam int REPORT_MAX = 10;

  // the unused request selector
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } console_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [REQ_W-1:0]     in_req_type = '0;
  logic [CHAR_W-1:0]    in_char_code = '0;
  logic [IDX_W-1:0]     in_cell_index = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [ROW_OUT_W-1:0] out_cur_row;
  logic [COL_OUT_W-1:0] out_cur_col;
  logic [POS_W-1:0]     out_cursor_pos;
  logic [CELL_W-1:0]    out_cell_data;
  logic                 out_scrolled;
  logic                 cfg_wr_en = 1'b0;
  logic [COLOR_W-1:0]   cfg_wr_data = '0;

  // requests waiting to be sent and cursor reports waiting to arrive
  console_req_t request_backlog[$];
  res_t         cursor_reports[$];
  int           requests_queued = 0;
  int           mismatch_count = 0;
  bit           steady = 1'b0;

  // console shadow state
  logic [CELL_W-1:0]  screen_shadow [NCELLS];
  int unsigned        row_shadow;
  int unsigned        col_shadow;
  logic [COLOR_W-1:0] attr_shadow;

  text_console_cursor_engine_top #(
    .COLS(SCR_COLS),
    .ROWS(SCR_ROWS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_cur_row    (out_cur_row),
    .out_cur_col    (out_cur_col),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // advance the shadow console by one request and build the cursor report
  task automatic console_step(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx, output res_t rep);
    int unsigned       row;
    int unsigned       col;
    logic [CELL_W-1:0] data;
    logic              scr;
    row  = row_shadow;
    col  = col_shadow;
    data = '0;
    scr  = 1'b0;
    case (req)
      REQ_PUT: begin
        if (ch == CH_NEWLINE) begin
          col = 0;
          row++;
        end else if (ch == CH_RETURN) begin
          col = 0;
        end else if (ch == CH_BACKSPACE) begin
          if (col > 0) begin
            col--;
            screen_shadow[row * SCR_COLS + col] = {attr_shadow, CH_SPACE};
          end
        end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
          screen_shadow[row * SCR_COLS + col] = {attr_shadow, ch};
          col++;
        end
        // row wrap, then scroll past the last row
        if (col >= SCR_COLS) begin
          col = 0;
          row++;
        end
        if (row >= SCR_ROWS) begin
          for (int i = 0; i < NCELLS - SCR_COLS; i++) screen_shadow[i] = screen_shadow[i + SCR_COLS];
          for (int i = NCELLS - SCR_COLS; i < NCELLS; i++) screen_shadow[i] = {attr_shadow, CH_SPACE};
          row = SCR_ROWS - 1;
          scr = 1'b1;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) screen_shadow[i] = {attr_shadow, CH_SPACE};
        row = 0;
        col = 0;
      end
      REQ_READ: begin
        if (idx < NCELLS) data = screen_shadow[idx];
      end
      default: ;
    endcase
    row_shadow   = row;
    col_shadow   = col;
    rep.row      = row[ROW_OUT_W-1:0];
    rep.col      = col[COL_OUT_W-1:0];
    rep.pos      = POS_W'(row * SCR_COLS + col);
    rep.data     = data;
    rep.scrolled = scr;
  endtask

  // request driver: one transaction per accepted push
  always @(posedge clk) begin : request_driver
    console_req_t nxt;
    res_t         want;
    if (!rst_n) begin
      in_push <= 1'b0;
      for (int i = 0; i < NCELLS; i++) screen_shadow[i] = RESET_CELL;
      row_shadow  = 0;
      col_shadow  = 0;
      attr_shadow = COLOR_RESET;
    end else begin
      if (cfg_wr_en) attr_shadow = cfg_wr_data;
      if (in_push && !in_full) begin
        console_step(in_req_type, in_char_code, in_cell_index, want);
        cursor_reports.push_back(want);
      end
      if (!in_push || !in_full) begin
        if (request_backlog.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = request_backlog.pop_front();
          in_push       <= 1'b1;
          in_req_type   <= nxt.req;
          in_char_code  <= nxt.ch;
          in_cell_index <= nxt.idx;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each popped transaction with the oldest report
  always @(posedge clk) begin : report_monitor
    res_t want;
    res_t got;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        got = '{row: out_cur_row, col: out_cur_col, pos: out_cursor_pos,
                data: out_cell_data, scrolled: out_scrolled};
        if (cursor_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: unexpected result row %0d col %0d pos %0d data %h scrolled %0b",
                     $time, got.row, got.col, got.pos, got.data, got.scrolled);
        end else begin
          want = cursor_reports.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.pos !== want.pos ||
              got.data !== want.data || got.scrolled !== want.scrolled) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("%0t: wrong result, expected row %0d col %0d pos %0d data %h scrolled %0b",
                       $time, want.row, want.col, want.pos, want.data, want.scrolled);
              $display("%0t:              actual row %0d col %0d pos %0d data %h scrolled %0b",
                       $time, got.row, got.col, got.pos, got.data, got.scrolled);
            end
          end
        end
      end
      out_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic queue_request(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                               input logic [IDX_W-1:0] idx);
    request_backlog.push_back('{req: req, ch: ch, idx: idx});
    requests_queued++;
  endtask

  task automatic queue_put(input logic [CHAR_W-1:0] ch);
    queue_request(REQ_PUT, ch, IDX_W'($urandom_range(2047)));
  endtask

  // read index: half anywhere on the screen, most others in the bottom five rows, a few past the screen
  function automatic logic [IDX_W-1:0] pick_index();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return IDX_W'($urandom_range(NCELLS, 2047));
    if (sel < 5)
      return IDX_W'($urandom_range(SCR_ROWS - 5, SCR_ROWS - 1) * SCR_COLS
                    + $urandom_range(SCR_COLS - 1));
    return IDX_W'($urandom_range(NCELLS - 1));
  endfunction

  // wait until no transaction is in flight, then let any background sweep finish
  task automatic wait_drained();
    do @(posedge clk);
    while (request_backlog.size() != 0 || in_push || cursor_reports.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_color(input logic [COLOR_W-1:0] color);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // random phase: text runs, newline bursts, edits and ignored bytes, mixed with reads, spare requests and clears
  task automatic fill_phase(input int count);
    int target;
    int kind;
    int len;
    target = requests_queued + count;
    while (requests_queued < target) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        len = $urandom_range(1, 40);
        repeat (len) queue_put(CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
      end else if (kind < 55) begin
        len = $urandom_range(1, 20);
        repeat (len) queue_put(CH_NEWLINE);
      end else if (kind < 63) begin
        queue_put(CH_RETURN);
        len = $urandom_range(0, 5);
        repeat (len) queue_put(CHAR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
      end else if (kind < 71) begin
        len = $urandom_range(1, 4);
        repeat (len) queue_put(CH_BACKSPACE);
      end else if (kind < 76) begin
        if ($urandom_range(1)) queue_put(CHAR_W'($urandom_range(0, CH_PRINT_LO - 1)));
        else queue_put(CHAR_W'($urandom_range(CH_PRINT_HI + 1, 255)));
      end else if (kind < 95) begin
        len = $urandom_range(1, 6);
        repeat (len) queue_request(REQ_READ, CHAR_W'($urandom_range(255)), pick_index());
      end else if (kind < 97) begin
        queue_request(REQ_SPARE, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
      end else if (kind < 98) begin
        queue_request(REQ_CLEAR, CHAR_W'($urandom_range(255)), IDX_W'($urandom_range(2047)));
      end else begin
        // noise: any field value at all
        queue_request(REQ_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                      IDX_W'($urandom_range(2047)));
      end
    end
  endtask

  // reset, directed checks, then random phases under several colors
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset contents and read range edges
    queue_request(REQ_READ, 8'h00, 11'd0);
    queue_request(REQ_READ, 8'h00, IDX_W'(NCELLS - 1));
    queue_request(REQ_READ, 8'h00, IDX_W'(NCELLS));
    queue_request(REQ_READ, 8'hFF, 11'd2047);
    // printable edges and ignored bytes
    queue_put(8'h41);
    queue_put(CH_PRINT_HI);
    queue_put(CH_PRINT_LO);
    queue_put(CH_PRINT_LO - 8'd1);
    queue_put(CH_PRINT_HI + 8'd1);
    queue_put(8'hFF);
    queue_put(8'h00);
    // backspace, return, backspace at column zero, newline
    queue_put(CH_BACKSPACE);
    queue_put(CH_RETURN);
    queue_put(CH_BACKSPACE);
    queue_put(CH_NEWLINE);
    queue_request(REQ_SPARE, 8'hFF, 11'd2047);
    queue_request(REQ_READ, 8'h00, 11'd0);
    queue_request(REQ_READ, 8'h00, 11'd1);
    queue_request(REQ_READ, 8'h00, 11'd2);
    queue_request(REQ_READ, 8'h00, IDX_W'(SCR_COLS));
    queue_request(REQ_CLEAR, 8'h00, 11'd0);
    queue_request(REQ_READ, 8'h00, 11'd0);
    wait_drained();

    write_color(8'h00);
    fill_phase(PHASE_LEN);
    wait_drained();

    write_color(8'hFF);
    fill_phase(PHASE_LEN);
    wait_drained();

    // long stretch with no idling on either side
    write_color(COLOR_W'($urandom_range(255)));
    steady = 1'b1;
    fill_phase(PHASE_LEN);
    wait_drained();
    steady = 1'b0;

    write_color(8'h1E);
    fill_phase(PHASE_LEN);
    wait_drained();

    write_color(COLOR_W'($urandom_range(255)));
    fill_phase(PHASE_LEN);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, long enough even if every request were a full-screen clear
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_fifo.sv
rtl/tcce_front.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine_top.sv
rtl/tcce_checker.sv
tb/sv/tb.sv
